// ----- rtl/apt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_pkg
// Types and constants shared by the animation phase timeline and its checker.
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int PROGRESS_BITS = 16;
    localparam int RAW_W         = PROGRESS_BITS + 1;
    localparam int PROG_W        = 17;
    localparam int DELAY_W       = 25;
    localparam int ACC_W         = 40;
    localparam int DUR_W         = 24;
    localparam int SPAN_W        = DUR_W + 8;
    localparam int DELTA_W       = 16;
    localparam int RATE_W        = 16;
    localparam int PROD_W        = DELTA_W + RATE_W;
    localparam int CNT_W         = $clog2(ACC_W);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;

    localparam logic [RAW_W-1:0] FULL_SCALE = {1'b1, {PROGRESS_BITS{1'b0}}};

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_PLAY    = 3'd1;
    localparam logic [2:0] OP_PAUSE   = 3'd2;
    localparam logic [2:0] OP_RESUME  = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;
    localparam logic [2:0] OP_RESTART = 3'd5;

    localparam logic [1:0] LOOP_ONCE     = 2'd0;
    localparam logic [1:0] LOOP_REPEAT   = 2'd1;
    localparam logic [1:0] LOOP_PINGPONG = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_Q8      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_KIND    = 2'd3;

    typedef enum logic [1:0] {
        RS_IDLE    = 2'd0,
        RS_PLAYING = 2'd1,
        RS_PAUSED  = 2'd2,
        RS_DONE    = 2'd3
    } run_state_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_ACCUM,
        SQ_MOD,
        SQ_DIV,
        SQ_FINISH,
        SQ_WRITE
    } seq_state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [DELTA_W-1:0] delta_time;
        logic               owner_alive;
    } cmd_item_t;

    typedef struct packed {
        logic [PROG_W-1:0] progress;
        logic              update_fired;
        logic              start_event;
        logic              complete_event;
        logic [1:0]        run_status;
    } rsp_item_t;

endpackage

// ----- rtl/animation_phase_timeline.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_phase_timeline
// Normalised ramp generator (Q1.16 progress) with once, loop and ping-pong.
//
// Usage:
//   cmd (valid/ready) carries one request: tick, play, pause, resume, stop
//   or restart. Every request yields exactly one rsp (valid/ready) item with
//   progress, the event flags and the run status after the request.
//   cfg_wen/cfg_idx/cfg_wdata write start_delay, run_duration, rate_q8 and
//   loop_kind; write them only while no request is in flight.
//   One request at a time passes a small sequencer around a shared
//   restoring subtract/compare unit:
//     commands and ignored ticks : straight from decode to write-back
//     zero duration or end, once : no divide
//     playing tick, no wrap      : 16 quotient steps
//     playing tick with wrap     : 40 remainder steps, then 16 quotient steps
//   cmd_ready returns as the result is loaded into the rsp register, so a
//   stalled receiver holds only the last result; the next request is worked
//   on meanwhile and waits before write-back.
//   Reset: idle, counters clear, rate 1.0, once mode, zero delay/duration.
// ----------------------------------------------------------------------------
module animation_phase_timeline
    import apt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_item_t             cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_item_t             rsp,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    seq_state_t              seq_reg, seq_next;

    logic [DUR_W-1:0]        start_delay_reg, start_delay_next;
    logic [DUR_W-1:0]        run_duration_reg, run_duration_next;
    logic [RATE_W-1:0]       rate_q8_reg, rate_q8_next;
    logic [1:0]              loop_kind_reg, loop_kind_next;

    run_state_t              run_state_reg, run_state_next;
    logic [DELAY_W-1:0]      delay_count_reg, delay_count_next;
    logic [ACC_W-1:0]        elapsed_acc_reg, elapsed_acc_next;
    logic                    direction_flip_reg, direction_flip_next;
    logic                    start_done_reg, start_done_next;

    logic [2:0]              op_reg, op_next;
    logic [DELTA_W-1:0]      delta_reg, delta_next;
    logic                    alive_reg, alive_next;

    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [SPAN_W-1:0]       rem_reg, rem_next;
    logic [ACC_W-1:0]        dividend_reg, dividend_next;
    logic [PROGRESS_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    full_reg, full_next;
    logic [RAW_W-1:0]        prog_reg, prog_next;
    logic                    upd_reg, upd_next;
    logic                    started_reg, started_next;
    logic                    completed_reg, completed_next;

    rsp_item_t               rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    logic                    rate_neg;
    logic [RATE_W-1:0]       rate_mag;
    logic [DELAY_W:0]        delay_sum;
    logic [DELAY_W-1:0]      delay_sat;
    logic                    delay_reached;
    logic                    tick_live;
    logic                    go_accum;
    logic [ACC_W:0]          acc_sum;
    logic [ACC_W-1:0]        acc_sat;
    logic [SPAN_W-1:0]       span;
    logic                    span_zero;
    logic                    wraps;
    logic                    acc_over;
    logic                    step_bit;
    logic [SPAN_W:0]         step_t;
    logic                    step_ge;
    logic [SPAN_W-1:0]       step_r;
    logic                    cnt_zero;
    logic                    rsp_free;
    logic [RAW_W-1:0]        raw;

    assign rate_neg      = rate_q8_reg[RATE_W-1];
    assign rate_mag      = rate_neg ? (~rate_q8_reg + 1'b1) : rate_q8_reg;
    assign delay_sum     = {1'b0, delay_count_reg} + {{(DELAY_W+1-DELTA_W){1'b0}}, delta_reg};
    assign delay_sat     = delay_sum[DELAY_W] ? {DELAY_W{1'b1}} : delay_sum[DELAY_W-1:0];
    assign delay_reached = delay_sat >= {{(DELAY_W-DUR_W){1'b0}}, start_delay_reg};
    assign tick_live     = (op_reg == OP_TICK) && (run_state_reg == RS_PLAYING) && alive_reg;
    assign go_accum      = tick_live && (start_done_reg || delay_reached);
    assign acc_sum       = {1'b0, elapsed_acc_reg} + {{(ACC_W+1-PROD_W){1'b0}}, prod_reg};
    assign acc_sat       = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    assign span          = {run_duration_reg, 8'd0};
    assign span_zero     = (run_duration_reg == '0);
    assign wraps         = (loop_kind_reg == LOOP_REPEAT) || (loop_kind_reg == LOOP_PINGPONG);
    assign acc_over      = acc_sat >= {{(ACC_W-SPAN_W){1'b0}}, span};
    assign cnt_zero      = (cnt_reg == '0);
    assign rsp_free      = !rsp_valid_reg || rsp_ready;

    // shared restoring step: remainder steps feed dividend bits, quotient steps feed zeros
    assign step_bit = (seq_reg == SQ_MOD) ? dividend_reg[ACC_W-1] : 1'b0;
    assign step_t   = {rem_reg, step_bit};
    assign step_ge  = step_t >= {1'b0, span};
    assign step_r   = step_ge ? SPAN_W'(step_t - {1'b0, span}) : step_t[SPAN_W-1:0];

    assign raw = full_reg ? FULL_SCALE : {1'b0, quo_reg};

    assign cmd_ready = (seq_reg == SQ_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (cmd_valid)
                    seq_next = SQ_DECODE;
            end
            SQ_DECODE: seq_next = go_accum ? SQ_ACCUM : SQ_WRITE;
            SQ_ACCUM:
            begin
                if (span_zero)
                    seq_next = SQ_FINISH;
                else if (acc_over)
                    seq_next = wraps ? SQ_MOD : SQ_FINISH;
                else
                    seq_next = SQ_DIV;
            end
            SQ_MOD:
            begin
                if (cnt_zero)
                    seq_next = SQ_DIV;
            end
            SQ_DIV:
            begin
                if (cnt_zero)
                    seq_next = SQ_FINISH;
            end
            SQ_FINISH: seq_next = SQ_WRITE;
            SQ_WRITE:
            begin
                if (rsp_free)
                    seq_next = SQ_IDLE;
            end
            default: seq_next = SQ_IDLE;
        endcase
    end

    always_comb
    begin
        start_delay_next    = start_delay_reg;
        run_duration_next   = run_duration_reg;
        rate_q8_next        = rate_q8_reg;
        loop_kind_next      = loop_kind_reg;
        run_state_next      = run_state_reg;
        delay_count_next    = delay_count_reg;
        elapsed_acc_next    = elapsed_acc_reg;
        direction_flip_next = direction_flip_reg;
        start_done_next     = start_done_reg;
        op_next             = op_reg;
        delta_next          = delta_reg;
        alive_next          = alive_reg;
        prod_next           = prod_reg;
        rem_next            = rem_reg;
        dividend_next       = dividend_reg;
        quo_next            = quo_reg;
        cnt_next            = cnt_reg;
        full_next           = full_reg;
        prog_next           = prog_reg;
        upd_next            = upd_reg;
        started_next        = started_reg;
        completed_next      = completed_reg;
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg && !rsp_ready;

        if (cfg_wen)
        begin
            case (cfg_idx)
                REG_START_DELAY:  start_delay_next  = cfg_wdata[DUR_W-1:0];
                REG_RUN_DURATION: run_duration_next = cfg_wdata[DUR_W-1:0];
                REG_RATE_Q8:      rate_q8_next      = cfg_wdata[RATE_W-1:0];
                REG_LOOP_KIND:    loop_kind_next    = cfg_wdata[1:0];
                default: ;
            endcase
        end

        case (seq_reg)
            SQ_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next        = cmd.op;
                    delta_next     = cmd.delta_time;
                    alive_next     = cmd.owner_alive;
                    full_next      = 1'b0;
                    prog_next      = '0;
                    upd_next       = 1'b0;
                    started_next   = 1'b0;
                    completed_next = 1'b0;
                end
            end
            SQ_DECODE:
            begin
                prod_next = PROD_W'(delta_reg) * PROD_W'(rate_mag);
                case (op_reg)
                    OP_PLAY, OP_RESTART, OP_STOP:
                    begin
                        delay_count_next    = '0;
                        elapsed_acc_next    = '0;
                        direction_flip_next = 1'b0;
                        start_done_next     = 1'b0;
                        run_state_next      = (op_reg == OP_STOP) ? RS_IDLE : RS_PLAYING;
                    end
                    OP_PAUSE:
                    begin
                        if (run_state_reg == RS_PLAYING)
                            run_state_next = RS_PAUSED;
                    end
                    OP_RESUME:
                    begin
                        if (run_state_reg == RS_PAUSED)
                            run_state_next = RS_PLAYING;
                    end
                    OP_TICK:
                    begin
                        if (run_state_reg == RS_PLAYING)
                        begin
                            if (!alive_reg)
                            begin
                                delay_count_next    = '0;
                                elapsed_acc_next    = '0;
                                direction_flip_next = 1'b0;
                                start_done_next     = 1'b0;
                                run_state_next      = RS_IDLE;
                            end
                            else if (!start_done_reg)
                            begin
                                delay_count_next = delay_sat;
                                if (delay_reached)
                                begin
                                    start_done_next = 1'b1;
                                    started_next    = 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            SQ_ACCUM:
            begin
                if (span_zero)
                begin
                    elapsed_acc_next = '0;
                    full_next        = 1'b1;
                    if (loop_kind_reg == LOOP_PINGPONG)
                        direction_flip_next = !direction_flip_reg;
                    else if (loop_kind_reg != LOOP_REPEAT)
                    begin
                        run_state_next = RS_DONE;
                        completed_next = 1'b1;
                    end
                end
                else if (acc_over && !wraps)
                begin
                    elapsed_acc_next = acc_sat;
                    full_next        = 1'b1;
                    run_state_next   = RS_DONE;
                    completed_next   = 1'b1;
                end
                else if (acc_over)
                begin
                    dividend_next = acc_sat;
                    rem_next      = '0;
                    cnt_next      = CNT_W'(ACC_W - 1);
                    if (loop_kind_reg == LOOP_PINGPONG)
                        direction_flip_next = !direction_flip_reg;
                end
                else
                begin
                    elapsed_acc_next = acc_sat;
                    rem_next         = acc_sat[SPAN_W-1:0];
                    cnt_next         = CNT_W'(PROGRESS_BITS - 1);
                    quo_next         = '0;
                end
            end
            SQ_MOD:
            begin
                rem_next      = step_r;
                dividend_next = {dividend_reg[ACC_W-2:0], 1'b0};
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    elapsed_acc_next = {{(ACC_W-SPAN_W){1'b0}}, step_r};
                    cnt_next         = CNT_W'(PROGRESS_BITS - 1);
                    quo_next         = '0;
                end
            end
            SQ_DIV:
            begin
                rem_next = step_r;
                quo_next = {quo_reg[PROGRESS_BITS-2:0], step_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            SQ_FINISH:
            begin
                upd_next  = 1'b1;
                prog_next = (rate_neg != direction_flip_reg) ? (FULL_SCALE - raw) : raw;
            end
            SQ_WRITE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.progress       = PROG_W'(prog_reg);
                    rsp_next.update_fired   = upd_reg;
                    rsp_next.start_event    = started_reg;
                    rsp_next.complete_event = completed_reg;
                    rsp_next.run_status     = run_state_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg            <= SQ_IDLE;
            start_delay_reg    <= '0;
            run_duration_reg   <= '0;
            rate_q8_reg        <= RATE_W'(256);
            loop_kind_reg      <= LOOP_ONCE;
            run_state_reg      <= RS_IDLE;
            delay_count_reg    <= '0;
            elapsed_acc_reg    <= '0;
            direction_flip_reg <= 1'b0;
            start_done_reg     <= 1'b0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            seq_reg            <= seq_next;
            start_delay_reg    <= start_delay_next;
            run_duration_reg   <= run_duration_next;
            rate_q8_reg        <= rate_q8_next;
            loop_kind_reg      <= loop_kind_next;
            run_state_reg      <= run_state_next;
            delay_count_reg    <= delay_count_next;
            elapsed_acc_reg    <= elapsed_acc_next;
            direction_flip_reg <= direction_flip_next;
            start_done_reg     <= start_done_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        delta_reg     <= delta_next;
        alive_reg     <= alive_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        dividend_reg  <= dividend_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        full_reg      <= full_next;
        prog_reg      <= prog_next;
        upd_reg       <= upd_next;
        started_reg   <= started_next;
        completed_reg <= completed_next;
        rsp_reg       <= rsp_next;
    end

endmodule

// ----- rtl/apt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks for the animation phase timeline, bound to the top level.
// ----------------------------------------------------------------------------
module apt_checker
    import apt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input rsp_item_t             rsp
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // one request in flight at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd_ready high straight after accept");

    a_no_update_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.update_fired |->
            rsp.progress == '0 && !rsp.start_event && !rsp.complete_event)
        else $error("flags or progress set without update");

    a_complete_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.complete_event |->
            rsp.run_status == RS_DONE && rsp.progress == PROG_W'(FULL_SCALE) ||
            rsp_valid && rsp.complete_event && rsp.run_status == RS_DONE &&
            rsp.progress == '0)
        else $error("completion without done state at an end point");

    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.progress <= PROG_W'(FULL_SCALE))
        else $error("progress above full scale");

endmodule

bind animation_phase_timeline apt_checker u_apt_checker (.*);

// ----- tb/animation_phase_timeline_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_phase_timeline_tb
// A short table of directed requests covers idle commands, reserved op codes,
// pause and resume, a lost owner, zero duration, ping-pong and the spare loop
// kind. Random phases follow, one register setting each, under different
// idle and stall mixes. Every response is checked against its table entry or
// an in-bench model of the timeline.
// ----------------------------------------------------------------------------
module animation_phase_timeline_tb;
    import apt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          N_DIRECTED  = 26;
    localparam int          N_PHASES    = 8;

    localparam logic [2:0]  OP_RSVD6   = 3'd6;
    localparam logic [2:0]  OP_RSVD7   = 3'd7;
    localparam logic [1:0]  LOOP_SPARE = 2'd3;
    localparam logic        KNOWN      = 1'b1;
    localparam logic        PRED       = 1'b0;
    localparam rsp_item_t   ANY        = '0;

    typedef struct packed {
        logic [23:0] delay;
        logic [23:0] duration;
        logic [15:0] rate;
        logic [1:0]  loop_kind;
    } setting_t;

    typedef struct packed {
        logic [2:0] set_idx;
        cmd_item_t  req;
        logic       known;
        rsp_item_t  want;
    } dir_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    cmd_item_t             cmd       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_item_t             rsp;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    animation_phase_timeline u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // timeline model state
    run_state_t  tl_state     = RS_IDLE;
    logic [24:0] tl_delay_cnt = '0;
    logic [39:0] tl_elapsed   = '0;
    logic        tl_flip      = 1'b0;
    logic        tl_started   = 1'b0;
    setting_t    cur_setting  = '{24'd0, 24'd0, 16'h0100, LOOP_ONCE};

    rsp_item_t   expected_progress_q [$];
    setting_t    dir_settings [5];
    dir_row_t    directed_rows [N_DIRECTED];

    int          tx_idle_pct      = 0;
    int          rx_stall_pct     = 0;
    int          rx_hold_left     = 0;
    int          fail_count       = 0;
    int          requests_sent    = 0;
    int          settings_used    = 0;
    int          updates_seen     = 0;
    int          starts_seen      = 0;
    int          completions_seen = 0;
    int unsigned cycle_count      = 0;

    function automatic void clear_run();
        tl_delay_cnt = '0;
        tl_elapsed   = '0;
        tl_flip      = 1'b0;
        tl_started   = 1'b0;
    endfunction

    function automatic rsp_item_t advance_timeline(input cmd_item_t c);
        rsp_item_t   r;
        logic        neg;
        logic        done;
        logic [16:0] mag;
        logic [63:0] sum;
        logic [63:0] span;
        logic [63:0] raw;
        r    = '0;
        done = 1'b0;
        case (c.op)
            OP_PLAY, OP_RESTART:
            begin
                clear_run();
                tl_state = RS_PLAYING;
            end
            OP_PAUSE:  if (tl_state == RS_PLAYING) tl_state = RS_PAUSED;
            OP_RESUME: if (tl_state == RS_PAUSED) tl_state = RS_PLAYING;
            OP_STOP:
            begin
                clear_run();
                tl_state = RS_IDLE;
            end
            OP_TICK:
            begin
                if (tl_state == RS_PLAYING && !c.owner_alive)
                begin
                    clear_run();
                    tl_state = RS_IDLE;
                end
                else if (tl_state == RS_PLAYING)
                begin
                    if (!tl_started)
                    begin
                        sum = 64'(tl_delay_cnt) + 64'(c.delta_time);
                        if (sum > 64'h1FF_FFFF) sum = 64'h1FF_FFFF;
                        tl_delay_cnt = sum[24:0];
                        if (tl_delay_cnt >= 25'(cur_setting.delay))
                        begin
                            tl_started    = 1'b1;
                            r.start_event = 1'b1;
                        end
                    end
                    if (tl_started)
                    begin
                        neg  = cur_setting.rate[15];
                        mag  = neg ? 17'h10000 - {1'b0, cur_setting.rate}
                                   : {1'b0, cur_setting.rate};
                        sum  = 64'(tl_elapsed) + 64'(c.delta_time) * 64'(mag);
                        if (sum > 64'hFF_FFFF_FFFF) sum = 64'hFF_FFFF_FFFF;
                        span = 64'(cur_setting.duration) << 8;
                        if (span == 0)
                        begin
                            sum = '0;
                            raw = 64'(FULL_SCALE);
                            if (cur_setting.loop_kind == LOOP_PINGPONG) tl_flip = ~tl_flip;
                            else if (cur_setting.loop_kind != LOOP_REPEAT) done = 1'b1;
                        end
                        else
                        begin
                            if (sum >= span)
                            begin
                                if (cur_setting.loop_kind == LOOP_REPEAT
                                    || cur_setting.loop_kind == LOOP_PINGPONG)
                                begin
                                    sum = sum % span;
                                    if (cur_setting.loop_kind == LOOP_PINGPONG)
                                        tl_flip = ~tl_flip;
                                end
                                else
                                    done = 1'b1;
                            end
                            raw = done ? 64'(FULL_SCALE) : (sum << PROGRESS_BITS) / span;
                        end
                        if (done) tl_state = RS_DONE;
                        tl_elapsed       = sum[39:0];
                        r.progress       = (neg != tl_flip) ? PROG_W'(64'(FULL_SCALE) - raw)
                                                            : PROG_W'(raw);
                        r.update_fired   = 1'b1;
                        r.complete_event = done;
                    end
                end
            end
            default: ;
        endcase
        r.run_status = tl_state;
        return r;
    endfunction

    function automatic cmd_item_t random_request(input int tick_pct, input bit big);
        cmd_item_t c;
        int        k;
        k             = $urandom_range(0, 99);
        c.owner_alive = big || ($urandom_range(0, 99) < 97);
        if (tl_state != RS_PLAYING && (big || k < 30))
            c.op = OP_PLAY;
        else if (big || $urandom_range(0, 99) < tick_pct)
            c.op = OP_TICK;
        else
        begin
            k = $urandom_range(0, 99);
            if (k < 20)      c.op = OP_PLAY;
            else if (k < 40) c.op = OP_PAUSE;
            else if (k < 60) c.op = OP_RESUME;
            else if (k < 72) c.op = OP_STOP;
            else if (k < 88) c.op = OP_RESTART;
            else if (k < 94) c.op = OP_RSVD6;
            else             c.op = OP_RSVD7;
        end
        case ($urandom_range(0, 3))
            0:       c.delta_time = 16'($urandom_range(0, 65535));
            1:       c.delta_time = 16'($urandom_range(0, 255));
            2:       c.delta_time = 16'($urandom_range(0, 4095));
            default: c.delta_time = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        if (big) c.delta_time = 16'($urandom_range(60000, 65535));
        return c;
    endfunction

    function automatic void report_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
        $display("%0t tb: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        fail_count++;
    endfunction

    task automatic check_response(input rsp_item_t got);
        rsp_item_t want;
        if (expected_progress_q.size() == 0)
        begin
            $display("%0t tb: response with nothing pending, got %h", $time, got);
            fail_count++;
        end
        else
        begin
            want = expected_progress_q.pop_front();
            if (got.progress !== want.progress)
                report_field("progress", 32'(want.progress), 32'(got.progress));
            if (got.update_fired !== want.update_fired)
                report_field("update_fired", 32'(want.update_fired), 32'(got.update_fired));
            if (got.start_event !== want.start_event)
                report_field("start_event", 32'(want.start_event), 32'(got.start_event));
            if (got.complete_event !== want.complete_event)
                report_field("complete_event", 32'(want.complete_event),
                             32'(got.complete_event));
            if (got.run_status !== want.run_status)
                report_field("run_status", 32'(want.run_status), 32'(got.run_status));
            updates_seen     += int'(got.update_fired);
            starts_seen      += int'(got.start_event);
            completions_seen += int'(got.complete_event);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready) check_response(rsp);
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input cmd_item_t c, input logic known, input rsp_item_t want);
        rsp_item_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        predicted = advance_timeline(c);
        expected_progress_q.push_back(known ? want : predicted);
        requests_sent++;
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (expected_progress_q.size() != 0);
    endtask

    task automatic apply_setting(input setting_t s);
        cfg_wen   <= 1'b1;
        cfg_idx   <= REG_START_DELAY;
        cfg_wdata <= s.delay;
        @(posedge clk);
        cfg_idx   <= REG_RUN_DURATION;
        cfg_wdata <= s.duration;
        @(posedge clk);
        cfg_idx   <= REG_RATE_Q8;
        cfg_wdata <= {8'h00, s.rate};
        @(posedge clk);
        cfg_idx   <= REG_LOOP_KIND;
        cfg_wdata <= {22'd0, s.loop_kind};
        @(posedge clk);
        cfg_wen   <= 1'b0;
        cur_setting = s;
        settings_used++;
    endtask

    initial
    begin
        setting_t s;
        int       cur_set;
        int       n_items;
        int       tick_pct;
        bit       big;

        dir_settings = '{
            {24'd0,       24'd0,       16'h0100, LOOP_ONCE},
            {24'd100,     24'd1000,    16'hFF00, LOOP_PINGPONG},
            {24'd0,       24'd0,       16'h8000, LOOP_PINGPONG},
            {24'd0,       24'd0,       16'h7FFF, LOOP_REPEAT},
            {24'd0,       24'd1,       16'h0001, LOOP_SPARE}
        };
        directed_rows = '{
            {3'd0, {OP_TICK,    16'hFFFF, 1'b1}, KNOWN, {17'd0, 3'b000, RS_IDLE}},
            {3'd0, {OP_RSVD6,   16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_IDLE}},
            {3'd0, {OP_RSVD7,   16'hFFFF, 1'b0}, KNOWN, {17'd0, 3'b000, RS_IDLE}},
            {3'd0, {OP_PAUSE,   16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_IDLE}},
            {3'd0, {OP_RESUME,  16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_IDLE}},
            {3'd0, {OP_PLAY,    16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd0, {OP_TICK,    16'h0000, 1'b1}, KNOWN, {FULL_SCALE, 3'b111, RS_DONE}},
            {3'd0, {OP_RESTART, 16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd0, {OP_PAUSE,   16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PAUSED}},
            {3'd0, {OP_TICK,    16'h0040, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PAUSED}},
            {3'd0, {OP_RESUME,  16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd0, {OP_TICK,    16'h0010, 1'b0}, KNOWN, {17'd0, 3'b000, RS_IDLE}},
            {3'd0, {OP_PLAY,    16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd0, {OP_STOP,    16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_IDLE}},
            {3'd1, {OP_PLAY,    16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd1, {OP_TICK,    16'd60,   1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd1, {OP_TICK,    16'hFFFF, 1'b1}, PRED,  ANY},
            {3'd1, {OP_TICK,    16'd1000, 1'b1}, PRED,  ANY},
            {3'd2, {OP_PLAY,    16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd2, {OP_TICK,    16'h0001, 1'b1}, PRED,  ANY},
            {3'd2, {OP_TICK,    16'h0000, 1'b1}, PRED,  ANY},
            {3'd3, {OP_PLAY,    16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd3, {OP_TICK,    16'hFFFF, 1'b1}, KNOWN, {FULL_SCALE, 3'b110, RS_PLAYING}},
            {3'd4, {OP_PLAY,    16'h0000, 1'b1}, KNOWN, {17'd0, 3'b000, RS_PLAYING}},
            {3'd4, {OP_TICK,    16'd255,  1'b1}, PRED,  ANY},
            {3'd4, {OP_TICK,    16'h0001, 1'b1}, KNOWN, {FULL_SCALE, 3'b101, RS_DONE}}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values match the first directed setting
        cur_set = 0;
        foreach (directed_rows[i])
        begin
            if (int'(directed_rows[i].set_idx) != cur_set)
            begin
                drain();
                cur_set = int'(directed_rows[i].set_idx);
                apply_setting(dir_settings[cur_set]);
            end
            send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            n_items  = 110;
            tick_pct = 80;
            big      = 1'b0;
            case (p)
                0:
                begin
                    s = {24'($urandom_range(0, 300)), 24'($urandom_range(1, 3000)),
                         16'($urandom), LOOP_PINGPONG};
                    tx_idle_pct = 0;  rx_stall_pct = 0;
                end
                1:
                begin
                    s = {24'($urandom_range(0, 500)), 24'($urandom_range(1, 5000)),
                         16'($urandom), LOOP_REPEAT};
                    tx_idle_pct = 48; rx_stall_pct = 0;
                end
                2:
                begin
                    s = {24'($urandom_range(0, 100)), 24'($urandom_range(1, 800)),
                         16'($urandom), LOOP_ONCE};
                    tx_idle_pct = 0;  rx_stall_pct = 48;
                end
                3:
                begin
                    s = {24'($urandom_range(0, 50)), 24'd0, 16'($urandom),
                         2'($urandom_range(0, 3))};
                    tx_idle_pct = 24; rx_stall_pct = 24; n_items = 80;
                end
                4:
                begin
                    // delay and duration at their maxima: about 260 ticks before the start
                    s = {24'hFF_FFFF, 24'hFF_FFFF, 16'h8000, LOOP_PINGPONG};
                    tx_idle_pct = 0;  rx_stall_pct = 0; n_items = 300; big = 1'b1;
                end
                5:
                begin
                    s = {24'($urandom_range(0, 2000)), 24'($urandom_range(0, 24'hFF_FFFF)),
                         16'($urandom), 2'($urandom_range(0, 3))};
                    tx_idle_pct = 24; rx_stall_pct = 24;
                end
                6:
                begin
                    s = {24'd0, 24'd1, 16'h7FFF, LOOP_REPEAT};
                    tx_idle_pct = 48; rx_stall_pct = 0; n_items = 60;
                end
                default:
                begin
                    s = {24'($urandom_range(0, 50)), 24'($urandom_range(1, 65535)),
                         16'h0000, LOOP_ONCE};
                    tx_idle_pct = 0;  rx_stall_pct = 48; n_items = 60;
                end
            endcase
            drain();
            apply_setting(s);
            for (int i = 0; i < n_items; i++)
            begin
                // long response hold-off fills the block; later the sender waits it out
                if (p == 0 && i == 20) rx_hold_left = 400;
                if (p == 0 && i == 70) drain();
                send_request(random_request(tick_pct, big), PRED, ANY);
            end
        end

        drain();
        rx_stall_pct = 0;
        repeat (80) @(posedge clk);

        $display("tb: %0d requests over %0d register settings, idle, stall and hold-off mixes",
                 requests_sent, settings_used);
        $display("tb: %0d progress updates, %0d delay ends, %0d completions checked",
                 updates_seen, starts_seen, completions_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
